@@ src/ssa_pkg.sv @@
// Shared types, constants and helpers of the slab slot allocator.
package ssa_pkg;

  localparam int MAX_SLABS      = 64;
  localparam int SLOTS_PER_SLAB = 64;

  localparam int SLAB_W   = $clog2(MAX_SLABS);
  localparam int SLOT_W   = $clog2(SLOTS_PER_SLAB);
  localparam int LVL_W    = $clog2(SLOTS_PER_SLAB + 1);
  localparam int OPEN_W   = $clog2(MAX_SLABS + 1);
  localparam int STK_AW   = SLAB_W + SLOT_W;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = ((SLAB_W + SLOT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SLAB_W + SLOT_W + STATUS_W + 7) / 8) * 8;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_OPEN  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SLAB_FULL = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [SLAB_W-1:0] slab_number;
    logic [SLOT_W-1:0] slot_number;
  } ssa_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [SLAB_W-1:0]   granted_slab;
  } ssa_result_t;

  // Per-slab bookkeeping: stack depth and lowest depth ever reached.
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] low;
  } ssa_meta_t;

  // Lowest set bit of a slab bitmap.
  function automatic logic [SLAB_W-1:0] ssa_first_set(input logic [MAX_SLABS-1:0] v);
    logic [SLAB_W-1:0] idx;
    idx = '0;
    for (int i = MAX_SLABS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLAB_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ src/slab_slot_allocator_unit.sv @@
// Top level of the slab slot allocator.
// Hands out and takes back slots from up to MAX_SLABS slabs of SLOTS_PER_SLAB
// slots each. An allocate beat (tuser 0) pops the free-index stack of the
// lowest slab that still has a free slot, opening the next slab when none
// has; a release beat (tuser 1) pushes the slot back onto its slab's stack.
// One beat is worked on at a time. A release reads the per-slab metadata RAM,
// and an allocate reads the metadata RAM and then the stack RAM, before the
// result beat is loaded into the output register; a stalled output register
// holds the input off until it frees.
// The lowest slab with free slots comes from a bitmap and a priority encoder,
// so no search runs over cycles. No clearing pass follows reset: the initial
// stack order of each slab is produced from a per-slab low-water mark, so
// the stack RAM is only ever read where it has been written. A finished
// result waits in the output register while the next beat is accepted.
// Status codes: 0 ok, 1 pool full, 2 release slab not open, 3 release into
// a full slab; granted fields are zero unless an allocate succeeds.
module slab_slot_allocator_unit
  import ssa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [5:0] slab_number, [11:6] slot_number
  input  logic                   s_tuser,   // operation: 0 allocate, 1 release
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [5:0] granted_slab, [11:6] granted_slot,
                                            // [13:12] status
);

  ssa_item_t          in_item;
  logic               meta_re;
  logic [SLAB_W-1:0]  meta_raddr;
  ssa_meta_t          meta_rdata;
  logic               meta_we;
  logic [SLAB_W-1:0]  meta_waddr;
  ssa_meta_t          meta_wdata;
  logic               stk_re;
  logic [STK_AW-1:0]  stk_raddr;
  logic [SLOT_W-1:0]  stk_rdata;
  logic               stk_we;
  logic [STK_AW-1:0]  stk_waddr;
  logic [SLOT_W-1:0]  stk_wdata;
  logic               res_valid;
  ssa_result_t        res;
  logic               res_free;

  // Unpack the input beat.
  assign in_item.operation   = s_tuser;
  assign in_item.slab_number = s_tdata[SLAB_W-1:0];
  assign in_item.slot_number = s_tdata[SLAB_W +: SLOT_W];

  // Per-slab stack depth and low-water mark.
  ssa_ram #(
    .WIDTH ($bits(ssa_meta_t)),
    .DEPTH (MAX_SLABS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // Free-index stacks of all slabs, one row of SLOTS_PER_SLAB per slab.
  ssa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLABS * SLOTS_PER_SLAB)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  ssa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .meta_re    (meta_re),
    .meta_raddr (meta_raddr),
    .meta_rdata (meta_rdata),
    .meta_we    (meta_we),
    .meta_waddr (meta_waddr),
    .meta_wdata (meta_wdata),
    .stk_re     (stk_re),
    .stk_raddr  (stk_raddr),
    .stk_rdata  (stk_rdata),
    .stk_we     (stk_we),
    .stk_waddr  (stk_waddr),
    .stk_wdata  (stk_wdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_free   (res_free)
  );

  // Result beat register.
  ssa_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ src/ssa_ram.sv @@
// Generic single-port-write, registered-read RAM.
module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ssa_ctrl.sv @@
// Allocation sequencer: slab bitmap, metadata and stack read-modify-write.
module ssa_ctrl
  import ssa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ssa_item_t               in_item,
  output logic                    meta_re,
  output logic [SLAB_W-1:0]       meta_raddr,
  input  ssa_meta_t               meta_rdata,
  output logic                    meta_we,
  output logic [SLAB_W-1:0]       meta_waddr,
  output ssa_meta_t               meta_wdata,
  output logic                    stk_re,
  output logic [STK_AW-1:0]       stk_raddr,
  input  logic [SLOT_W-1:0]       stk_rdata,
  output logic                    stk_we,
  output logic [STK_AW-1:0]       stk_waddr,
  output logic [SLOT_W-1:0]       stk_wdata,
  output logic                    res_valid,
  output ssa_result_t             res,
  input  logic                    res_free
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_META = 2'd1;
  localparam logic [1:0] S_STK  = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  localparam logic [LVL_W-1:0]  LVL_FULL = LVL_W'(SLOTS_PER_SLAB);
  localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(SLOTS_PER_SLAB - 1);
  localparam logic [OPEN_W-1:0] OPEN_MAX = OPEN_W'(MAX_SLABS);

  logic [1:0]           state;
  logic [OPEN_W-1:0]    open_slabs;
  logic [MAX_SLABS-1:0] bitmap;
  logic                 op_q;
  logic [SLAB_W-1:0]    slab_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 opening_q;
  logic                 full_q;
  logic                 unopened_q;
  logic                 orig_q;
  logic [SLOT_W-1:0]    pos_q;
  ssa_result_t          res_q;

  logic                 accept;
  logic                 any_free;
  logic [SLAB_W-1:0]    first_free;
  logic [SLAB_W-1:0]    target;
  ssa_meta_t            cur;
  logic [LVL_W-1:0]     lvl_dec;
  logic                 orig;
  logic                 rel_ok;
  logic                 fin;
  ssa_result_t          fin_res;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign any_free   = |bitmap;
  assign first_free = ssa_first_set(bitmap);

  always_comb begin
    if (in_item.operation == OP_RELEASE) begin
      target = in_item.slab_number;
    end else if (any_free) begin
      target = first_free;
    end else begin
      target = open_slabs[SLAB_W-1:0];
    end
  end

  assign meta_re    = accept;
  assign meta_raddr = target;

  // A freshly opened slab has never been written: use its full-stack values.
  always_comb begin
    if (opening_q) begin
      cur.level = LVL_FULL;
      cur.low   = LVL_FULL;
    end else begin
      cur = meta_rdata;
    end
  end

  assign lvl_dec = cur.level - LVL_W'(1);
  // Entries below the low mark were never pushed; their values follow the initial order.
  assign orig    = (cur.level == cur.low);
  assign rel_ok  = !unopened_q && (cur.level != LVL_FULL);

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = slab_q;
    meta_wdata = cur;
    stk_re     = 1'b0;
    stk_raddr  = {slab_q, lvl_dec[SLOT_W-1:0]};
    stk_we     = 1'b0;
    stk_waddr  = {slab_q, cur.level[SLOT_W-1:0]};
    stk_wdata  = slot_q;
    if (state == S_META && !full_q) begin
      if (op_q == OP_ALLOC) begin
        meta_we          = 1'b1;
        meta_wdata.level = lvl_dec;
        meta_wdata.low   = orig ? lvl_dec : cur.low;
        stk_re           = !orig;
      end else if (rel_ok) begin
        meta_we          = 1'b1;
        meta_wdata.level = cur.level + LVL_W'(1);
        stk_we           = 1'b1;
      end
    end
  end

  always_comb begin
    fin                  = 1'b0;
    fin_res.granted_slab = '0;
    fin_res.granted_slot = '0;
    fin_res.status       = STATUS_OK;
    if (state == S_META && (full_q || op_q == OP_RELEASE)) begin
      fin = 1'b1;
      if (full_q) begin
        fin_res.status = STATUS_POOL_FULL;
      end else if (unopened_q) begin
        fin_res.status = STATUS_NOT_OPEN;
      end else if (cur.level == LVL_FULL) begin
        fin_res.status = STATUS_SLAB_FULL;
      end
    end else if (state == S_STK) begin
      fin                  = 1'b1;
      fin_res.granted_slab = slab_q;
      fin_res.granted_slot = orig_q ? (SLOT_TOP - pos_q) : stk_rdata;
    end
  end

  assign res_valid = fin || (state == S_PUT);
  assign res       = (state == S_PUT) ? res_q : fin_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      open_slabs <= '0;
      bitmap     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q       <= in_item.operation;
            slab_q     <= target;
            slot_q     <= in_item.slot_number;
            opening_q  <= (in_item.operation == OP_ALLOC) && !any_free;
            full_q     <= (in_item.operation == OP_ALLOC) && !any_free
                          && (open_slabs == OPEN_MAX);
            unopened_q <= ({1'b0, in_item.slab_number} >= (SLAB_W+1)'(open_slabs));
            state      <= S_META;
          end
        end
        S_META: begin
          if (op_q == OP_ALLOC && !full_q) begin
            orig_q         <= orig;
            pos_q          <= lvl_dec[SLOT_W-1:0];
            bitmap[slab_q] <= (lvl_dec != '0);
            if (opening_q) begin
              open_slabs <= open_slabs + OPEN_W'(1);
            end
            state <= S_STK;
          end else begin
            if (rel_ok && !full_q) begin
              bitmap[slab_q] <= 1'b1;
            end
            res_q <= fin_res;
            state <= res_free ? S_IDLE : S_PUT;
          end
        end
        S_STK: begin
          res_q <= fin_res;
          state <= res_free ? S_IDLE : S_PUT;
        end
        S_PUT: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/ssa_out.sv @@
// Output register of the result stream.
module ssa_out
  import ssa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  ssa_result_t            res,
  output logic                   res_free,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  assign res_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload needs no reset: hold it until the next beat loads.
  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      m_tdata <= OUT_TDATA_W'({res.status, res.granted_slot, res.granted_slab});
    end
  end

endmodule
